FILE: design/pts_pkg.sv
// Shared types and constants of the priority task scheduler.
// Used by pts_ctrl, pts_datapath and priority_task_scheduler; no dependencies.
package pts_pkg;

   localparam int SLOT_COUNT_DEF  = 64;
   localparam int LEVEL_COUNT_DEF = 16;

   localparam logic [2:0] CMD_CREATE   = 3'd0;
   localparam logic [2:0] CMD_EXIT     = 3'd1;
   localparam logic [2:0] CMD_RESCHED  = 3'd2;
   localparam logic [2:0] CMD_SCHEDULE = 3'd3;
   localparam logic [2:0] CMD_QUERY    = 3'd4;

   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_NO_FREE  = 3'd1;
   localparam logic [2:0] STS_BAD_PRIO = 3'd2;
   localparam logic [2:0] STS_NO_READY = 3'd3;
   localparam logic [2:0] STS_WRONG    = 3'd4;

   localparam logic [1:0] SLOT_FREE   = 2'd0;
   localparam logic [1:0] SLOT_READY  = 2'd1;
   localparam logic [1:0] SLOT_ACTIVE = 2'd2;

   localparam logic CSR_STACK_BASE = 1'b0;
   localparam logic CSR_STACK_SIZE = 1'b1;

   localparam logic [31:0] STACK_SIZE_RESET = 32'd131072;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] priority_req;
      logic [5:0] task_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  result_id;
      logic [47:0] stack_top;
      logic        is_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EXEC,
      ST_LINK,
      ST_MULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic look;
      logic exec;
      logic link;
      logic mult;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic need_link;
      logic out_free;
   } sts_type;

endpackage

FILE: design/pts_ctrl.sv
// Command sequencer of the priority task scheduler.
// Depends on pts_pkg; drives pts_datapath through ctl_type and reads sts_type.
module pts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pts_pkg::sts_type sts,
   output pts_pkg::ctl_type ctl
);
   import pts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = sts.need_link ? ST_LINK : ST_MULT;
         end
         ST_LINK: state_in = ST_MULT;
         ST_MULT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctl.accept = req_valid;
         end
         ST_LOOK:   ctl.look = 1'b1;
         ST_EXEC:   ctl.exec = 1'b1;
         ST_LINK:   ctl.link = 1'b1;
         ST_MULT:   ctl.mult = 1'b1;
         ST_FINISH: ctl.finish = 1'b1;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_link_only_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK |-> $past(state_ff) == ST_EXEC)
      else $error("link step without exec step");
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !sts.out_free |=> state_ff == ST_FINISH)
      else $error("finish left while output busy");
   a_idle_after_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && $past(state_ff) != ST_IDLE |-> $past(state_ff) == ST_FINISH)
      else $error("idle reached without finish");
`endif

endmodule

FILE: design/pts_datapath.sv
// Datapath of the priority task scheduler: slot tables, ready queues, free list,
// stack arithmetic and result register. Depends on pts_pkg.
module pts_datapath #(
   parameter int SLOT_COUNT  = pts_pkg::SLOT_COUNT_DEF,
   parameter int LEVEL_COUNT = pts_pkg::LEVEL_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pts_pkg::ctl_type ctl,
   output pts_pkg::sts_type sts,
   input  pts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pts_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [47:0]      csr_wdata
);
   import pts_pkg::*;

   localparam int IdW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LvlW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam logic [IdW-1:0] LastId = IdW'(SLOT_COUNT - 1);

   logic [1:0]      state_mem [SLOT_COUNT];
   logic [LvlW-1:0] prio_mem  [SLOT_COUNT];
   logic [IdW-1:0]  link_mem  [SLOT_COUNT];
   logic [IdW-1:0]  fifo_mem  [SLOT_COUNT];
   logic [IdW-1:0]  head_mem  [LEVEL_COUNT];
   logic [IdW-1:0]  tail_mem  [LEVEL_COUNT];

   logic [47:0]            stack_base_ff;
   logic [31:0]            stack_size_ff;
   req_type                req_ff;
   logic [SLOT_COUNT-1:0]  state_vld_ff, state_vld_in;
   logic [SLOT_COUNT-1:0]  fifo_vld_ff, fifo_vld_in;
   logic [LEVEL_COUNT-1:0] nonempty_ff, nonempty_in;
   logic [IdW-1:0]         free_rd_ptr_ff, free_rd_ptr_in;
   logic [IdW-1:0]         free_wr_ptr_ff, free_wr_ptr_in;
   logic [IdW:0]           free_count_ff, free_count_in;

   logic [1:0]      state_rd_ff;
   logic            state_vld_rd_ff;
   logic [LvlW-1:0] prio_rd_ff;
   logic [IdW-1:0]  fifo_rd_ff;
   logic            fifo_vld_rd_ff;
   logic [LvlW-1:0] lvl_ff;
   logic [IdW-1:0]  head_rd_ff;
   logic [IdW-1:0]  tail_rd_ff;
   logic [IdW-1:0]  link_rd_ff;

   logic [2:0]      res_status_ff, res_status_in;
   logic [IdW-1:0]  res_id_ff, res_id_in;
   logic            res_valid_ff, res_valid_in;
   logic            top_en_ff, top_en_in;
   logic [47:0]     prod_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [IdW-1:0]  acc_tid;
   logic [IdW-1:0]  tid_idx;
   logic            tid_ok;
   logic [LvlW-1:0] top_lvl;
   logic            any_ne;
   logic [LvlW-1:0] lvl_sel;
   logic [1:0]      cur_state;
   logic            active_ok;
   logic [IdW-1:0]  new_id;
   logic            lvl_ne;
   logic            prio_ok;
   logic            enq;
   logic [IdW-1:0]  enq_id;
   logic            st_we;
   logic [IdW-1:0]  st_wa;
   logic [1:0]      st_wd;
   logic            pr_we;
   logic            lk_we;
   logic            hd_we;
   logic [IdW-1:0]  hd_wd;
   logic            tl_we;
   logic            ff_we;
   logic            need_link;
   logic [IdW+31:0] prod_c;
   logic            out_free;

   assign acc_tid = IdW'(req_payload.task_id);
   assign tid_idx = IdW'(req_ff.task_id);
   assign tid_ok  = 32'(req_ff.task_id) < SLOT_COUNT;
   assign prio_ok = 32'(req_ff.priority_req) < LEVEL_COUNT;
   assign any_ne  = |nonempty_ff;

   always_comb begin
      top_lvl = '0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         if (nonempty_ff[l]) top_lvl = LvlW'(l);
      end
   end

   always_comb begin
      unique case (req_ff.cmd)
         CMD_CREATE:  lvl_sel = LvlW'(req_ff.priority_req);
         CMD_RESCHED: lvl_sel = prio_rd_ff;
         default:     lvl_sel = top_lvl;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_base_ff <= '0;
         stack_size_ff <= STACK_SIZE_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_STACK_BASE) stack_base_ff <= csr_wdata;
         if (csr_addr == CSR_STACK_SIZE) stack_size_ff <= csr_wdata[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff          <= req_payload;
         state_rd_ff     <= state_mem[acc_tid];
         state_vld_rd_ff <= state_vld_ff[acc_tid];
         prio_rd_ff      <= prio_mem[acc_tid];
         fifo_rd_ff      <= fifo_mem[free_rd_ptr_ff];
         fifo_vld_rd_ff  <= fifo_vld_ff[free_rd_ptr_ff];
      end
      if (ctl.look) begin
         lvl_ff     <= lvl_sel;
         head_rd_ff <= head_mem[lvl_sel];
         tail_rd_ff <= tail_mem[lvl_sel];
      end
      if (ctl.exec) begin
         link_rd_ff <= link_mem[head_rd_ff];
      end
   end

   assign cur_state = state_vld_rd_ff ? state_rd_ff : SLOT_FREE;
   assign active_ok = tid_ok && (cur_state == SLOT_ACTIVE);
   assign new_id    = fifo_vld_rd_ff ? fifo_rd_ff : free_rd_ptr_ff;
   assign lvl_ne    = nonempty_ff[lvl_ff];

   always_comb begin
      free_rd_ptr_in = free_rd_ptr_ff;
      free_wr_ptr_in = free_wr_ptr_ff;
      free_count_in  = free_count_ff;
      nonempty_in    = nonempty_ff;
      state_vld_in   = state_vld_ff;
      fifo_vld_in    = fifo_vld_ff;
      res_status_in  = res_status_ff;
      res_id_in      = res_id_ff;
      res_valid_in   = res_valid_ff;
      top_en_in      = top_en_ff;
      enq            = 1'b0;
      enq_id         = tid_idx;
      st_we          = 1'b0;
      st_wa          = tid_idx;
      st_wd          = SLOT_FREE;
      pr_we          = 1'b0;
      ff_we          = 1'b0;
      hd_we          = 1'b0;
      hd_wd          = link_rd_ff;
      need_link      = 1'b0;
      if (ctl.exec) begin
         res_status_in = STS_OK;
         res_id_in     = '0;
         res_valid_in  = 1'b0;
         top_en_in     = 1'b0;
         unique case (req_ff.cmd)
            CMD_CREATE: begin
               if (free_count_ff == '0) begin
                  res_status_in = STS_NO_FREE;
               end else if (!prio_ok) begin
                  res_status_in = STS_BAD_PRIO;
               end else begin
                  free_rd_ptr_in = (free_rd_ptr_ff == LastId) ? '0 : free_rd_ptr_ff + 1'b1;
                  free_count_in  = free_count_ff - 1'b1;
                  pr_we          = 1'b1;
                  enq            = 1'b1;
                  enq_id         = new_id;
                  res_id_in      = new_id;
                  top_en_in      = 1'b1;
               end
            end
            CMD_EXIT: begin
               if (!active_ok) begin
                  res_status_in = STS_WRONG;
               end else begin
                  st_we          = 1'b1;
                  ff_we          = 1'b1;
                  fifo_vld_in[free_wr_ptr_ff] = 1'b1;
                  free_wr_ptr_in = (free_wr_ptr_ff == LastId) ? '0 : free_wr_ptr_ff + 1'b1;
                  free_count_in  = free_count_ff + 1'b1;
               end
            end
            CMD_RESCHED: begin
               if (!active_ok) res_status_in = STS_WRONG;
               else enq = 1'b1;
            end
            CMD_SCHEDULE: begin
               if (!any_ne) begin
                  res_status_in = STS_NO_READY;
               end else begin
                  if (head_rd_ff == tail_rd_ff) nonempty_in[lvl_ff] = 1'b0;
                  else need_link = 1'b1;
                  st_we     = 1'b1;
                  st_wa     = head_rd_ff;
                  st_wd     = SLOT_ACTIVE;
                  res_id_in = head_rd_ff;
                  state_vld_in[head_rd_ff] = 1'b1;
               end
            end
            CMD_QUERY: begin
               res_valid_in = tid_ok && (cur_state != SLOT_FREE);
            end
            default: ;
         endcase
         if (enq) begin
            st_we = 1'b1;
            st_wa = enq_id;
            st_wd = SLOT_READY;
            state_vld_in[enq_id] = 1'b1;
            if (!lvl_ne) begin
               hd_we = 1'b1;
               hd_wd = enq_id;
               nonempty_in[lvl_ff] = 1'b1;
            end
         end
      end
      if (ctl.link) hd_we = 1'b1;
   end

   assign lk_we = enq && lvl_ne;
   assign tl_we = enq;

   always_ff @(posedge clock) begin
      if (st_we) state_mem[st_wa] <= st_wd;
      if (pr_we) prio_mem[new_id] <= lvl_ff;
      if (lk_we) link_mem[tail_rd_ff] <= enq_id;
      if (ff_we) fifo_mem[free_wr_ptr_ff] <= tid_idx;
      if (hd_we) head_mem[lvl_ff] <= hd_wd;
      if (tl_we) tail_mem[lvl_ff] <= enq_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_rd_ptr_ff <= '0;
         free_wr_ptr_ff <= '0;
         free_count_ff  <= (IdW + 1)'(SLOT_COUNT);
         nonempty_ff    <= '0;
         state_vld_ff   <= '0;
         fifo_vld_ff    <= '0;
      end else begin
         free_rd_ptr_ff <= free_rd_ptr_in;
         free_wr_ptr_ff <= free_wr_ptr_in;
         free_count_ff  <= free_count_in;
         nonempty_ff    <= nonempty_in;
         state_vld_ff   <= state_vld_in;
         fifo_vld_ff    <= fifo_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_valid_ff  <= res_valid_in;
      top_en_ff     <= top_en_in;
   end

   assign prod_c = res_id_ff * stack_size_ff;

   always_ff @(posedge clock) begin
      if (ctl.mult) prod_ff <= 48'(prod_c);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish && out_free) begin
         rsp_ff.status    <= res_status_ff;
         rsp_ff.result_id <= 6'(res_id_ff);
         rsp_ff.stack_top <= top_en_ff ? stack_base_ff - prod_ff : '0;
         rsp_ff.is_valid  <= res_valid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;
   assign sts.need_link = need_link;
   assign sts.out_free  = out_free;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= (IdW + 1)'(SLOT_COUNT))
      else $error("free count above slot count");
   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff == '0 || free_count_ff == (IdW + 1)'(SLOT_COUNT))
      |-> free_rd_ptr_ff == free_wr_ptr_ff)
      else $error("free list pointers disagree with count");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STS_OK
      |-> rsp_ff.result_id == '0 && rsp_ff.stack_top == '0)
      else $error("error item carries data");
`endif

endmodule

FILE: design/priority_task_scheduler.sv
// Priority task scheduler: slot allocator with multilevel FIFO ready queues.
// Commands arrive as items on req_*; one result item per command leaves on rsp_*.
// Create pops a free slot and queues it ready at its priority; exit frees the
// active slot; reschedule requeues it; schedule pops the oldest ready slot of the
// highest nonempty level; query reports whether a slot is in use.
// A command passes the idle (accept), look, exec, mult and finish steps, with a link
// step after exec for a schedule that advances a queue head, before its result is
// valid; the next command is accepted once the block is back at idle. The steps hold
// the registered reads of the slot tables, the queue head/tail tables and the link
// table, then the slot id times stack size product. One item is in work at a time.
// The result sits in an output register; while rsp_stall is high it holds and the
// next command waits at its finish step, and req_stall stays high meanwhile.
// Reset is synchronous and active high: all slots free, queues empty, the free
// list holding ids in order, stack_base 0 and stack_size 131072. The csr port
// writes stack_base (index 0) and stack_size (index 1); the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
module priority_task_scheduler #(
   parameter int SLOT_COUNT  = pts_pkg::SLOT_COUNT_DEF,
   parameter int LEVEL_COUNT = pts_pkg::LEVEL_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pts_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [47:0]      csr_wdata
);
   import pts_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   pts_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

endmodule

FILE: tb/priority_task_scheduler_test.sv
// Self-checking testbench for priority_task_scheduler: random and directed commands,
// predicted by an in-bench slot/ready-queue model and compared item by item.
// Depends on pts_pkg and the priority_task_scheduler RTL.
`timescale 1ns / 1ps
module priority_task_scheduler_test;
   import pts_pkg::*;

   localparam int SLOTS = 64;
   localparam int LEVELS = 16;
   localparam int IDLE_LIMIT = 2000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_we;
   logic csr_addr;
   logic [47:0] csr_wdata;

   priority_task_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // scheduler shadow state
   logic [1:0]  slot_st [SLOTS];
   logic [3:0]  slot_pri [SLOTS];
   logic [5:0]  link [SLOTS];
   logic [5:0]  qhead [LEVELS];
   logic [5:0]  qtail [LEVELS];
   logic [15:0] qbusy;
   logic [5:0]  free_ids [SLOTS];
   logic [5:0]  free_rd;
   logic [5:0]  free_wr;
   logic [6:0]  free_n;
   logic [47:0] stack_base;
   logic [31:0] stack_size;

   req_type cmd_pending[$];
   rsp_type rsp_expected[$];
   int errors = 0;
   int cmds_made = 0;
   int cmds_sent = 0;
   int cmds_taken = 0;
   int rsps_taken = 0;
   int rsps_seen = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int take_gap = 0;
   bit calm = 1'b0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic push_ready(input logic [5:0] id, input logic [3:0] lvl);
      if (qbusy[lvl]) begin
         link[qtail[lvl]] = id;
      end else begin
         qhead[lvl] = id;
         qbusy[lvl] = 1'b1;
      end
      qtail[lvl] = id;
      slot_st[id] = SLOT_READY;
   endtask

   task automatic predict_scheduler(input req_type r);
      rsp_type o;
      logic [63:0] top;
      logic [5:0] id;
      o = '0;
      case (r.cmd)
         CMD_CREATE: begin
            if (free_n == 0) begin
               o.status = STS_NO_FREE;
            end else if (r.priority_req >= LEVELS) begin
               o.status = STS_BAD_PRIO;
            end else begin
               id = free_ids[free_rd];
               free_rd++;
               free_n--;
               slot_pri[id] = r.priority_req[3:0];
               push_ready(id, r.priority_req[3:0]);
               top = {16'b0, stack_base} - 64'(id) * 64'(stack_size);
               o.result_id = id;
               o.stack_top = top[47:0];
            end
         end
         CMD_EXIT: begin
            if (slot_st[r.task_id] != SLOT_ACTIVE) begin
               o.status = STS_WRONG;
            end else begin
               slot_st[r.task_id] = SLOT_FREE;
               free_ids[free_wr] = r.task_id;
               free_wr++;
               free_n++;
            end
         end
         CMD_RESCHED: begin
            if (slot_st[r.task_id] != SLOT_ACTIVE) o.status = STS_WRONG;
            else push_ready(r.task_id, slot_pri[r.task_id]);
         end
         CMD_SCHEDULE: begin
            o.status = STS_NO_READY;
            for (int l = LEVELS - 1; l >= 0; l--) begin
               if (qbusy[l] && o.status == STS_NO_READY) begin
                  id = qhead[l];
                  if (id == qtail[l]) qbusy[l] = 1'b0;
                  else qhead[l] = link[id];
                  slot_st[id] = SLOT_ACTIVE;
                  o.result_id = id;
                  o.status = STS_OK;
               end
            end
         end
         CMD_QUERY: o.is_valid = slot_st[r.task_id] != SLOT_FREE;
         default: ;
      endcase
      rsp_expected.push_back(o);
   endtask

   // sender and rsp_stall driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (cmds_taken == cmds_sent) begin
         if (req_valid) send_gap = draw_gap();
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (cmd_pending.size() > 0) begin
            req_payload <= cmd_pending.pop_front();
            req_valid <= 1'b1;
            cmds_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (rsps_taken != rsps_seen) begin
         rsps_seen = rsps_taken;
         take_gap = draw_gap();
      end
      if (take_gap > 0) begin
         take_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // acceptance, prediction and checking
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            predict_scheduler(req_payload);
            cmds_taken++;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            rsps_taken++;
            if (rsp_expected.size() == 0) begin
               report("unexpected item", 64'(rsp_payload), 64'(0));
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_payload.status !== e.status)
                  report("status", 64'(rsp_payload.status), 64'(e.status));
               if (rsp_payload.result_id !== e.result_id)
                  report("result_id", 64'(rsp_payload.result_id), 64'(e.result_id));
               if (rsp_payload.stack_top !== e.stack_top)
                  report("stack_top", 64'(rsp_payload.stack_top), 64'(e.stack_top));
               if (rsp_payload.is_valid !== e.is_valid)
                  report("is_valid", 64'(rsp_payload.is_valid), 64'(e.is_valid));
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send(input logic [2:0] c, input logic [7:0] p, input logic [5:0] t);
      req_type r;
      r.cmd = c;
      r.priority_req = p;
      r.task_id = t;
      cmd_pending.push_back(r);
      cmds_made++;
      wait (cmds_taken == cmds_made);
   endtask

   task automatic settle();
      wait (rsp_expected.size() == 0 && cmds_taken == cmds_made);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [47:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STACK_BASE) stack_base = val;
      else stack_size = val[31:0];
   endtask

   function automatic logic [5:0] pick_active();
      int n;
      int k;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_st[i] == SLOT_ACTIVE) n++;
      if (n == 0) return 6'($urandom);
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_st[i] == SLOT_ACTIVE) begin
            if (k == 0) return 6'(i);
            k--;
         end
      end
      return 6'd0;
   endfunction

   task automatic random_cmd(input int create_pct);
      int r;
      logic [7:0] p;
      r = $urandom_range(0, 99);
      p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, LEVELS - 1));
      if (r < create_pct) send(CMD_CREATE, p, 6'($urandom));
      else if (r < create_pct + 25) send(CMD_SCHEDULE, 8'($urandom), 6'($urandom));
      else if (r < create_pct + 40) send(CMD_EXIT, 8'($urandom), pick_active());
      else if (r < create_pct + 55) send(CMD_RESCHED, 8'($urandom), pick_active());
      else if (r < create_pct + 65) send(CMD_QUERY, 8'($urandom), 6'($urandom));
      else if (r < create_pct + 69) send(3'($urandom_range(5, 7)), 8'($urandom), 6'($urandom));
      else send(3'($urandom_range(1, 2)), 8'($urandom), 6'($urandom));
   endtask

   initial begin
      logic [47:0] bases [6];
      logic [31:0] sizes [6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_STACK_BASE;
      csr_wdata = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_st[i] = SLOT_FREE;
         slot_pri[i] = '0;
         link[i] = '0;
         free_ids[i] = 6'(i);
      end
      for (int l = 0; l < LEVELS; l++) begin
         qhead[l] = '0;
         qtail[l] = '0;
      end
      qbusy = '0;
      free_rd = '0;
      free_wr = '0;
      free_n = 7'(SLOTS);
      stack_base = '0;
      stack_size = STACK_SIZE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(CMD_QUERY, 8'hff, 6'd0);
      send(CMD_QUERY, 8'h00, 6'd63);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(CMD_EXIT, 8'h00, 6'd0);
      send(CMD_RESCHED, 8'h00, 6'd63);
      send(CMD_CREATE, 8'd16, 6'd0);
      send(CMD_CREATE, 8'd255, 6'd63);
      send(CMD_CREATE, 8'd0, 6'd0);
      send(CMD_CREATE, 8'd15, 6'd0);
      send(CMD_CREATE, 8'd15, 6'd0);
      send(CMD_QUERY, 8'h00, 6'd1);
      send(CMD_EXIT, 8'h00, 6'd1);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(CMD_RESCHED, 8'h00, 6'd1);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(CMD_EXIT, 8'h00, 6'd2);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(CMD_SCHEDULE, 8'h00, 6'd0);
      send(3'd5, 8'hff, 6'd63);
      send(3'd6, 8'h55, 6'd21);
      send(3'd7, 8'haa, 6'd42);

      bases = '{48'hffff_ffff_ffff, 48'h0, 48'h0, 48'h8000_0000_0000, 48'h7fff_f000_0000, 48'h0};
      sizes = '{32'hffff_ffff, 32'h0, 32'd1, 32'h0002_0000, 32'h8000_0000, 32'h0};
      bases[5] = {16'($urandom), 32'($urandom)};
      sizes[5] = 32'($urandom);
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         csr_write(CSR_STACK_BASE, bases[ph]);
         csr_write(CSR_STACK_SIZE, {16'b0, sizes[ph]});
         calm = (ph % 3 == 1);
         for (int n = 0; n < 240; n++) random_cmd((ph % 2 == 0) ? 40 : 20);
      end

      wait (rsp_expected.size() == 0 && cmds_taken == cmds_made);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: files.f
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_datapath.sv
design/priority_task_scheduler.sv
tb/priority_task_scheduler_test.sv
